// ===== sv/rtsf_pkg.sv =====
package rtsf_pkg;

    // Defaults for the top level parameters
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int MAX_REGIONS_DEF = 16;

    // Fixed field widths
    localparam int VALUE_W = 16;
    localparam int THR_W   = 7;
    localparam int REG_W   = 5;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [REG_W-1:0] NUM_REGIONS_RST = REG_W'(2);

    // Register word indexes
    localparam logic REG_NUM_REGIONS = 1'b0;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT_START,
        ST_SUM,
        ST_DIVL_START,
        ST_DIVL_WAIT,
        ST_DIVR_START,
        ST_DIVR_WAIT,
        ST_SSE,
        ST_CMP,
        ST_EMIT_SPLIT,
        ST_EMIT_FINAL,
        ST_EMIT_ERR
    } rtsf_state_t;

endpackage

// ===== sv/regression_tree_split_finder.sv =====
// Greedy least-squares regression tree splitter for one feature. Samples
// arrive one item per cycle and are stored at positions 0..K-1; the item with
// last_sample set starts the search, and no sample is taken until the last
// result of the run has been passed to the output register. Each split scans
// every cut of the current prefix of P+1 samples; one cut takes two passes
// over the sample memory (one read per cycle) plus two divisions in a shared
// restoring divider of one bit a cycle; a result may wait for the output
// register. num_regions results follow, clamped to 2..MAX_REGIONS:
// one per split, then the leftmost mean with last_result set. Too few samples,
// or a prefix that runs out, ends the run with a status 1 result.
module regression_tree_split_finder
    import rtsf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic signed [VALUE_W-1:0] sample_value,
    input  logic                      last_sample,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [THR_W-1:0]          threshold_x2,
    output logic signed [VALUE_W-1:0] region_mean,
    output logic                      status,
    output logic                      last_result
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CTW   = $clog2(MAX_SAMPLES + 1);
    localparam int RGW   = $clog2(MAX_REGIONS + 1);
    localparam int CMPW  = (RGW > REG_W ? RGW : REG_W) > CTW
                         ? (RGW > REG_W ? RGW : REG_W) : CTW;
    localparam int SUM_W = VALUE_W + AW + 1;
    localparam int DIF_W = VALUE_W + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam int COST_W = SQ_W + AW;

    rtsf_state_t state_reg, state_next;

    logic [REG_W-1:0]          nreg_reg;
    logic [CTW-1:0]            count_reg, count_next;
    logic [AW-1:0]             pe_reg,    pe_next;
    logic [CMPW-1:0]           split_reg, split_next;
    logic [AW-1:0]             cut_reg,   cut_next;
    logic [AW-1:0]             k_reg,     k_next;
    logic                      iss_reg,   iss_next;
    logic                      pv_reg,    pv_next;
    logic [AW-1:0]             pk_reg,    pk_next;
    logic                      sqv_reg,   sqv_next;
    logic [AW-1:0]             sqk_reg,   sqk_next;
    logic [SQ_W-1:0]           sq_reg,    sq_next;
    logic signed [SUM_W-1:0]   suml_reg,  suml_next;
    logic signed [SUM_W-1:0]   sumr_reg,  sumr_next;
    logic signed [VALUE_W-1:0] ml_reg,    ml_next;
    logic signed [VALUE_W-1:0] mr_reg,    mr_next;
    logic [COST_W-1:0]         cost_reg,  cost_next;
    logic [AW-1:0]             best_reg,  best_next;
    logic [COST_W-1:0]         bcost_reg, bcost_next;
    logic signed [VALUE_W-1:0] bml_reg,   bml_next;
    logic signed [VALUE_W-1:0] bmr_reg,   bmr_next;
    logic signed [VALUE_W-1:0] lmean_reg, lmean_next;
    logic                      ov_reg,    ov_next;
    logic [THR_W-1:0]          othr_reg,  othr_next;
    logic signed [VALUE_W-1:0] omean_reg, omean_next;
    logic                      ost_reg,   ost_next;
    logic                      olast_reg, olast_next;

    logic [CMPW-1:0]           nreg_ext;
    logic [CMPW-1:0]           eff_regions;
    logic [CTW-1:0]            cnt_new;
    logic [CTW-1:0]            cnt_m1;
    logic                      wr_en;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      div_start;
    logic signed [SUM_W-1:0]   div_dividend;
    logic [AW:0]               div_divisor;
    logic                      div_done;
    logic signed [SUM_W-1:0]   div_q;
    logic signed [DIF_W-1:0]   diff;
    logic signed [SQ_W-1:0]    prod;
    logic                      out_free;
    logic [31:0]               thr_wide;
    logic                      cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_REGIONS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nreg_reg <= NUM_REGIONS_RST;
        end
        else if (cfg_wr)
        begin
            nreg_reg <= pwdata[REG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_NUM_REGIONS) ? DATA_W'(nreg_reg) : '0;

    // Clamp the region count into its legal range
    assign nreg_ext    = CMPW'(nreg_reg);
    assign eff_regions = (nreg_ext < CMPW'(2)) ? CMPW'(2)
                       : (nreg_ext > CMPW'(MAX_REGIONS)) ? CMPW'(MAX_REGIONS) : nreg_ext;

    assign sample_stall = (state_reg != ST_IDLE);
    assign wr_en        = sample_valid && !sample_stall && (count_reg < CTW'(MAX_SAMPLES));
    assign cnt_new      = wr_en ? count_reg + CTW'(1) : count_reg;
    assign cnt_m1       = cnt_new - CTW'(1);

    rtsf_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (sample_value),
        .rd_addr (k_reg),
        .rd_data (rd_data)
    );

    assign div_start    = (state_reg == ST_DIVL_START) || (state_reg == ST_DIVR_START);
    assign div_dividend = (state_reg == ST_DIVL_START) ? suml_reg : sumr_reg;
    assign div_divisor  = (state_reg == ST_DIVL_START) ? ({1'b0, cut_reg} + (AW+1)'(1))
                                                       : ({1'b0, pe_reg} - {1'b0, cut_reg});

    rtsf_divider #(
        .SW (SUM_W),
        .DW (AW + 1)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Deviation of the sample from its part mean, and its square
    assign diff     = ((pk_reg <= cut_reg) ? DIF_W'(ml_reg) : DIF_W'(mr_reg)) - DIF_W'(rd_data);
    assign prod     = diff * diff;
    assign out_free = !ov_reg || !result_stall;
    assign thr_wide = 32'(best_reg) * 32'd2 + 32'd3;

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pe_next    = pe_reg;
        split_next = split_reg;
        cut_next   = cut_reg;
        k_next     = k_reg;
        iss_next   = 1'b0;
        pv_next    = iss_reg;
        pk_next    = k_reg;
        sqv_next   = 1'b0;
        sqk_next   = pk_reg;
        sq_next    = sq_reg;
        suml_next  = suml_reg;
        sumr_next  = sumr_reg;
        ml_next    = ml_reg;
        mr_next    = mr_reg;
        cost_next  = cost_reg;
        best_next  = best_reg;
        bcost_next = bcost_reg;
        bml_next   = bml_reg;
        bmr_next   = bmr_reg;
        lmean_next = lmean_reg;
        ov_next    = ov_reg && result_stall;
        othr_next  = othr_reg;
        omean_next = omean_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;

        // Advance the read address while a pass is running
        if (iss_reg)
        begin
            if (k_reg == pe_reg)
            begin
                iss_next = 1'b0;
            end
            else
            begin
                iss_next = 1'b1;
                k_next   = k_reg + AW'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                count_next = cnt_new;
                if (sample_valid && last_sample)
                begin
                    if (CMPW'(cnt_new) < eff_regions)
                    begin
                        state_next = ST_EMIT_ERR;
                    end
                    else
                    begin
                        pe_next    = cnt_m1[AW-1:0];
                        split_next = '0;
                        state_next = ST_SPLIT_START;
                    end
                end
            end
            ST_SPLIT_START:
            begin
                if (pe_reg == '0)
                begin
                    state_next = ST_EMIT_ERR;
                end
                else
                begin
                    cut_next   = '0;
                    suml_next  = '0;
                    sumr_next  = '0;
                    k_next     = '0;
                    iss_next   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (pv_reg)
                begin
                    if (pk_reg <= cut_reg)
                    begin
                        suml_next = suml_reg + SUM_W'(rd_data);
                    end
                    else
                    begin
                        sumr_next = sumr_reg + SUM_W'(rd_data);
                    end
                    if (pk_reg == pe_reg)
                    begin
                        state_next = ST_DIVL_START;
                    end
                end
            end
            ST_DIVL_START:
            begin
                state_next = ST_DIVL_WAIT;
            end
            ST_DIVL_WAIT:
            begin
                if (div_done)
                begin
                    ml_next    = div_q[VALUE_W-1:0];
                    state_next = ST_DIVR_START;
                end
            end
            ST_DIVR_START:
            begin
                state_next = ST_DIVR_WAIT;
            end
            ST_DIVR_WAIT:
            begin
                if (div_done)
                begin
                    mr_next    = div_q[VALUE_W-1:0];
                    cost_next  = '0;
                    k_next     = '0;
                    iss_next   = 1'b1;
                    state_next = ST_SSE;
                end
            end
            ST_SSE:
            begin
                sqv_next = pv_reg;
                if (pv_reg)
                begin
                    sq_next = SQ_W'(prod);
                end
                if (sqv_reg)
                begin
                    cost_next = cost_reg + COST_W'(sq_reg);
                    if (sqk_reg == pe_reg)
                    begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                // Keep the first cut of least cost
                if ((cut_reg == '0) || (cost_reg < bcost_reg))
                begin
                    best_next  = cut_reg;
                    bcost_next = cost_reg;
                    bml_next   = ml_reg;
                    bmr_next   = mr_reg;
                end
                if (cut_reg == pe_reg - AW'(1))
                begin
                    state_next = ST_EMIT_SPLIT;
                end
                else
                begin
                    cut_next   = cut_reg + AW'(1);
                    suml_next  = '0;
                    sumr_next  = '0;
                    k_next     = '0;
                    iss_next   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_EMIT_SPLIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    othr_next  = thr_wide[THR_W-1:0];
                    omean_next = bmr_reg;
                    ost_next   = STATUS_OK;
                    olast_next = 1'b0;
                    lmean_next = bml_reg;
                    pe_next    = best_reg;
                    split_next = split_reg + CMPW'(1);
                    if (split_reg + CMPW'(1) == eff_regions - CMPW'(1))
                    begin
                        state_next = ST_EMIT_FINAL;
                    end
                    else
                    begin
                        state_next = ST_SPLIT_START;
                    end
                end
            end
            ST_EMIT_FINAL:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    othr_next  = '0;
                    omean_next = lmean_reg;
                    ost_next   = STATUS_OK;
                    olast_next = 1'b1;
                    count_next = '0;
                    pe_next    = '0;
                    split_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_ERR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    othr_next  = '0;
                    omean_next = '0;
                    ost_next   = STATUS_ERR;
                    olast_next = 1'b1;
                    count_next = '0;
                    pe_next    = '0;
                    split_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pe_reg    <= '0;
            split_reg <= '0;
            iss_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            sqv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pe_reg    <= pe_next;
            split_reg <= split_next;
            iss_reg   <= iss_next;
            pv_reg    <= pv_next;
            sqv_reg   <= sqv_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cut_reg   <= cut_next;
        k_reg     <= k_next;
        pk_reg    <= pk_next;
        sqk_reg   <= sqk_next;
        sq_reg    <= sq_next;
        suml_reg  <= suml_next;
        sumr_reg  <= sumr_next;
        ml_reg    <= ml_next;
        mr_reg    <= mr_next;
        cost_reg  <= cost_next;
        best_reg  <= best_next;
        bcost_reg <= bcost_next;
        bml_reg   <= bml_next;
        bmr_reg   <= bmr_next;
        lmean_reg <= lmean_next;
        othr_reg  <= othr_next;
        omean_reg <= omean_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    assign result_valid = ov_reg;
    assign threshold_x2 = othr_reg;
    assign region_mean  = omean_reg;
    assign status       = ost_reg;
    assign last_result  = olast_reg;

endmodule

// ===== sv/rtsf_store.sv =====
module rtsf_store
    import rtsf_pkg::*;
#(
    parameter int DEPTH = MAX_SAMPLES_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    // Write one sample, read one sample a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rtsf_divider.sv =====
module rtsf_divider
    import rtsf_pkg::*;
#(
    parameter int SW = 23,
    parameter int DW = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [SW-1:0] dividend,
    input  logic [DW-1:0]        divisor,
    output logic                 done,
    output logic signed [SW-1:0] quotient
);

    localparam int CW = $clog2(SW + 1);

    logic [SW-1:0] mag_reg,  mag_next;
    logic [DW:0]   rem_reg,  rem_next;
    logic [DW-1:0] div_reg,  div_next;
    logic          neg_reg,  neg_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW+1:0] rem_shift;
    logic [DW+1:0] rem_diff;

    // One restoring step a cycle on the magnitude
    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_shift = {rem_reg, mag_reg[SW-1]};
        rem_diff  = rem_shift - {2'b00, div_reg};
        if (start)
        begin
            neg_next  = dividend[SW-1];
            mag_next  = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CW'(SW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!rem_diff[DW+1])
            begin
                rem_next = rem_diff[DW:0];
                mag_next = {mag_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DW:0];
                mag_next = {mag_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // Restore the sign: truncation toward zero
    assign done     = done_reg;
    assign quotient = neg_reg ? SW'(-mag_reg) : mag_reg;

endmodule
